FILE: rtl/core/itok_pkg.sv
// itok_pkg: shared types and constants of the irc line tokenizer
`default_nettype none

package itok_pkg;

  localparam int unsigned LEN_W     = 9;
  localparam int unsigned PCNT_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 9;

  localparam logic [LEN_W-1:0]  MAX_LINE_RST  = 9'd510;
  localparam logic [PCNT_W-1:0] MAX_PARAM_RST = 5'd15;
  localparam logic [LEN_W-1:0]  LEN_SAT       = 9'd511;
  localparam logic [PCNT_W-1:0] PCNT_SAT      = 5'd31;
  localparam logic [PCNT_W-1:0] PIDX_SAT      = 5'd16;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PARAMS = 2'd1;

  typedef enum logic [3:0] {
    PH_LEAD      = 4'd0,
    PH_PFX_COLON = 4'd1,
    PH_PREFIX    = 4'd2,
    PH_PRE_SP    = 4'd3,
    PH_CMD       = 4'd4,
    PH_CMD_SP    = 4'd5,
    PH_PARAM     = 4'd6,
    PH_PAR_SP    = 4'd7,
    PH_TRL_COLON = 4'd8,
    PH_TRAIL     = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    K_SEP    = 3'd0,
    K_PREFIX = 3'd1,
    K_CMD    = 3'd2,
    K_PARAM  = 3'd3,
    K_TRAIL  = 3'd4
  } kind_t;

  typedef struct packed {
    phase_t              phase;
    logic [LEN_W-1:0]    byte_count;
    logic [PCNT_W-1:0]   param_count;
    logic                bad_seen;
  } line_state_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          data;
    logic [PCNT_W-1:0]   pidx;
    logic                start;
    logic                line_end;
    logic                ok;
  } tok_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/itok_step.sv
// itok_step: per-byte labelling, counters and verdict of one line
`default_nettype none

module itok_step
  import itok_pkg::*;
(
  input  line_state_t          st,
  input  logic [7:0]           line_byte,
  input  logic                 is_last,
  input  logic [LEN_W-1:0]     max_line,
  input  logic [PCNT_W-1:0]    max_params,
  output line_state_t          st_nxt,
  output tok_result_t          res
);

  always_comb begin
    logic [LEN_W:0]    n_bytes;
    logic [PCNT_W:0]   n_par;
    logic [PCNT_W-1:0] pdec;
    logic              sp;
    logic              bump;
    logic              bad;
    phase_t            ph;
    logic [PCNT_W-1:0] pc;
    kind_t             kind;
    logic              start;
    logic              shape;

    sp      = (line_byte == CH_SPACE);
    bump    = 1'b0;
    kind    = K_SEP;
    start   = 1'b0;
    ph      = st.phase;
    n_bytes = {1'b0, st.byte_count} + {{LEN_W{1'b0}}, 1'b1};
    bad     = st.bad_seen | (n_bytes > {1'b0, max_line}) | (line_byte == CH_NUL) |
              ((line_byte == CH_CR) & ~is_last);

    if (!((line_byte == CH_CR) && is_last)) begin
      case (st.phase)
        PH_PFX_COLON, PH_PREFIX: begin
          if (sp) begin
            ph = PH_PRE_SP;
          end else begin
            kind  = K_PREFIX;
            start = (st.phase == PH_PFX_COLON);
            ph    = PH_PREFIX;
          end
        end
        PH_PRE_SP: begin
          if (!sp) begin
            kind  = K_CMD;
            start = 1'b1;
            ph    = PH_CMD;
          end
        end
        PH_CMD: begin
          if (sp) ph = PH_CMD_SP;
          else    kind = K_CMD;
        end
        PH_CMD_SP, PH_PAR_SP: begin
          if (!sp) begin
            bump = 1'b1;
            if (line_byte == CH_COLON) begin
              ph = PH_TRL_COLON;
            end else begin
              kind  = K_PARAM;
              start = 1'b1;
              ph    = PH_PARAM;
            end
          end
        end
        PH_PARAM: begin
          if (sp) ph = PH_PAR_SP;
          else    kind = K_PARAM;
        end
        PH_TRL_COLON: begin
          kind  = K_TRAIL;
          start = 1'b1;
          ph    = PH_TRAIL;
        end
        PH_TRAIL: begin
          kind = K_TRAIL;
        end
        default: begin
          // leading spaces, also any unused phase code
          if (sp) begin
            ph = PH_LEAD;
          end else if (line_byte == CH_COLON) begin
            ph = PH_PFX_COLON;
          end else begin
            kind  = K_CMD;
            start = 1'b1;
            ph    = PH_CMD;
          end
        end
      endcase
    end

    // parameter counter, saturating
    n_par = {1'b0, st.param_count} + {{PCNT_W{1'b0}}, 1'b1};
    pc    = st.param_count;
    if (bump) begin
      if (n_par > {1'b0, max_params}) bad = 1'b1;
      pc = n_par[PCNT_W] ? PCNT_SAT : n_par[PCNT_W-1:0];
    end

    res.kind = kind;
    res.data = line_byte;
    if ((kind == K_CMD) && (line_byte >= CH_LC_A) && (line_byte <= CH_LC_Z))
      res.data = line_byte - CASE_OFS;

    pdec     = pc - {{(PCNT_W-1){1'b0}}, 1'b1};
    res.pidx = '0;
    if (((kind == K_PARAM) || (kind == K_TRAIL)) && (pc != '0))
      res.pidx = (pdec > PIDX_SAT) ? PIDX_SAT : pdec;

    res.start    = start;
    res.line_end = is_last;
    shape        = (ph >= PH_CMD) && (ph <= PH_TRAIL);
    res.ok       = is_last & shape & ~bad;

    if (is_last) begin
      st_nxt.phase       = PH_LEAD;
      st_nxt.byte_count  = '0;
      st_nxt.param_count = '0;
      st_nxt.bad_seen    = 1'b0;
    end else begin
      st_nxt.phase       = ph;
      st_nxt.byte_count  = n_bytes[LEN_W] ? LEN_SAT : n_bytes[LEN_W-1:0];
      st_nxt.param_count = pc;
      st_nxt.bad_seen    = bad;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/itok_out_stage.sv
// itok_out_stage: result register with valid/stall toward the sink
`default_nettype none

module itok_out_stage
  import itok_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  tok_result_t res_in,
  input  logic        out_stall,
  output logic        free,
  output logic        out_valid,
  output tok_result_t res_out
);

  logic        valid_r;
  tok_result_t res_r;

  // free when empty or the held result leaves this cycle
  assign free      = ~valid_r | ~out_stall;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/irc_line_tokenizer_core.sv
// irc_line_tokenizer_core: top level of the byte-wise irc line tokenizer
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in_     | sink      | in_valid/in_stall   | in_line_byte, in_is_last
//  out_    | source    | out_valid/out_stall | out_field_kind, out_out_byte,
//          |           |                     | out_param_index, out_field_start,
//          |           |                     | out_line_end, out_line_ok
//  cfg_    | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  one transaction per cycle sustained while out_stall is low; a byte passes
//  through the input register, then the result register, on its way to the output
//  the per-line parse state is updated when a byte moves from the input
//  register into the result register, so each byte sees the state its
//  predecessor left
//  synchronous active-low reset empties both stages, clears the line state
//  and loads the limit registers with 510 bytes and 15 parameters
//  out_stall holds the result register; in_stall rises only when the input
//  register is full and the result register cannot take it
`default_nettype none

module irc_line_tokenizer_core
  import itok_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input byte channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_line_byte,
  input  logic                  in_is_last,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_field_kind,
  output logic [7:0]            out_out_byte,
  output logic [PCNT_W-1:0]     out_param_index,
  output logic                  out_field_start,
  output logic                  out_line_end,
  output logic                  out_line_ok,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data
);

  // limit registers
  logic [LEN_W-1:0]  max_line_r;
  logic [PCNT_W-1:0] max_params_r;

  // input register
  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_last_r;

  // per-line parse state
  line_state_t       state_r;
  line_state_t       state_nxt;

  tok_result_t       step_res;
  tok_result_t       out_res;
  logic              out_free;
  logic              advance;
  logic              in_accept;

  // config writes are always taken; a write to an unused index is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r   <= MAX_LINE_RST;
      max_params_r <= MAX_PARAM_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAX_LINE)   max_line_r   <= cfg_data[LEN_W-1:0];
      if (cfg_index == CFG_MAX_PARAMS) max_params_r <= cfg_data[PCNT_W-1:0];
    end
  end

  // the input register hands its byte on whenever the result register is free
  assign advance   = in_valid_r & out_free;
  assign in_stall  = in_valid_r & ~out_free;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_line_byte;
      in_last_r <= in_is_last;
    end
  end

  itok_step u_step (
    .st         (state_r),
    .line_byte  (in_byte_r),
    .is_last    (in_last_r),
    .max_line   (max_line_r),
    .max_params (max_params_r),
    .st_nxt     (state_nxt),
    .res        (step_res)
  );

  // line state commits only together with the byte that produced it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_LEAD;
      state_r.byte_count  <= '0;
      state_r.param_count <= '0;
      state_r.bad_seen    <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  itok_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_valid_r),
    .res_in    (step_res),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign out_field_kind  = out_res.kind;
  assign out_out_byte    = out_res.data;
  assign out_param_index = out_res.pidx;
  assign out_field_start = out_res.start;
  assign out_line_end    = out_res.line_end;
  assign out_line_ok     = out_res.ok;

`ifndef SYNTHESIS
  // a verdict only ever accompanies the last byte of a line
  a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_end |-> !out_line_ok)
    else $error("line_ok set on a byte that is not last");

  // only parameter and trailing bytes carry an index
  a_pidx_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_field_kind == K_SEP || out_field_kind == K_PREFIX ||
                  out_field_kind == K_CMD) |-> out_param_index == '0)
    else $error("param_index set outside parameter or trailing");

  // the line state starts over after the last byte moves on
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_last_r |=> state_r.byte_count == '0 &&
                             state_r.param_count == '0 && !state_r.bad_seen)
    else $error("line state not cleared after last byte");

  // the input side stalls only while a byte is held and cannot move on
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // a stalled result register keeps its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

FILE: sim/irc_line_tokenizer_core_tb.sv
// irc_line_tokenizer_core_tb: self-checking testbench of the irc line tokenizer core
module irc_line_tokenizer_core_tb
  import itok_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no transaction on any channel before the run is declared hung
  localparam int unsigned QUIET_LIMIT  = 2000;
  // random bytes per configuration phase
  localparam int unsigned PHASE_BYTES  = 95;
  localparam int unsigned PHASES       = 8;
  // register indexes past the two limits decode to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum logic {
    ROW_BYTE,
    ROW_REG
  } row_op_t;

  // one step of the directed part: a byte, or a register write
  typedef struct packed {
    row_op_t                op;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DAT_W-1:0]   val;
    logic                   last;
    logic                   pinned;
    tok_result_t            want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_line_byte;
  logic                 in_is_last;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           out_field_kind;
  logic [7:0]           out_out_byte;
  logic [PCNT_W-1:0]    out_param_index;
  logic                 out_field_start;
  logic                 out_line_end;
  logic                 out_line_ok;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // labels the predictor has worked out, oldest first
  tok_result_t          labels_due[$];
  // bytes of the line being built by the random part
  logic [7:0]           line_buf[$];
  plan_row_t            plan[$];

  // predictor copy of the limit registers and of the per-line state
  logic [LEN_W-1:0]     lim_bytes = MAX_LINE_RST;
  logic [PCNT_W-1:0]    lim_params = MAX_PARAM_RST;
  phase_t               ln_phase = PH_LEAD;
  logic [LEN_W-1:0]     ln_count = '0;
  logic [PCNT_W-1:0]    ln_params = '0;
  logic                 ln_bad = 1'b0;

  int unsigned          bytes_sent = 0;
  int unsigned          mismatches = 0;
  int unsigned          quiet_cycles = 0;
  int unsigned          stall_hold = 0;
  int unsigned          stall_pick;
  bit                   calm_in = 1'b0;
  tok_result_t          due;

  irc_line_tokenizer_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_line_byte    (in_line_byte),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_kind  (out_field_kind),
    .out_out_byte    (out_out_byte),
    .out_param_index (out_param_index),
    .out_field_start (out_field_start),
    .out_line_end    (out_line_end),
    .out_line_ok     (out_line_ok),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // append one byte to the line under construction
  function automatic void add_byte(input logic [7:0] b);
    line_buf = {line_buf, b};
  endfunction

  // append one row to the directed plan
  function automatic void add_row(input plan_row_t r);
    plan = {plan, r};
  endfunction

  // label one byte and advance the line state; the verdict comes with the last byte
  function automatic tok_result_t label_byte(input logic [7:0] b, input logic last);
    tok_result_t r;
    logic [LEN_W:0]  nb;
    logic [PCNT_W:0] np;
    logic            sp;
    r = '0;
    r.kind = K_SEP;
    r.data = b;
    r.line_end = last;
    sp = (b == CH_SPACE);
    // length check uses the limit in force now; the count saturates
    nb = {1'b0, ln_count} + 1'b1;
    if (nb > {1'b0, lim_bytes}) ln_bad = 1'b1;
    ln_count = (nb > {1'b0, LEN_SAT}) ? LEN_SAT : nb[LEN_W-1:0];
    if (b == CH_NUL || (b == CH_CR && !last)) ln_bad = 1'b1;
    // a closing cr is stripped: it is a separator and leaves the phase alone
    if (!(b == CH_CR && last)) begin
      case (ln_phase)
        PH_PFX_COLON, PH_PREFIX: begin
          if (sp) ln_phase = PH_PRE_SP;
          else begin
            r.kind = K_PREFIX;
            r.start = (ln_phase == PH_PFX_COLON);
            ln_phase = PH_PREFIX;
          end
        end
        PH_PRE_SP: begin
          if (!sp) begin
            r.kind = K_CMD;
            r.start = 1'b1;
            ln_phase = PH_CMD;
          end
        end
        PH_CMD: begin
          if (sp) ln_phase = PH_CMD_SP;
          else r.kind = K_CMD;
        end
        PH_CMD_SP, PH_PAR_SP: begin
          if (!sp) begin
            np = {1'b0, ln_params} + 1'b1;
            if (np > {1'b0, lim_params}) ln_bad = 1'b1;
            ln_params = (np > {1'b0, PCNT_SAT}) ? PCNT_SAT : np[PCNT_W-1:0];
            if (b == CH_COLON) ln_phase = PH_TRL_COLON;
            else begin
              r.kind = K_PARAM;
              r.start = 1'b1;
              ln_phase = PH_PARAM;
            end
          end
        end
        PH_PARAM: begin
          if (sp) ln_phase = PH_PAR_SP;
          else r.kind = K_PARAM;
        end
        PH_TRL_COLON: begin
          r.kind = K_TRAIL;
          r.start = 1'b1;
          ln_phase = PH_TRAIL;
        end
        PH_TRAIL: r.kind = K_TRAIL;
        default: begin
          if (sp) ln_phase = PH_LEAD;
          else if (b == CH_COLON) ln_phase = PH_PFX_COLON;
          else begin
            r.kind = K_CMD;
            r.start = 1'b1;
            ln_phase = PH_CMD;
          end
        end
      endcase
    end
    if (r.kind == K_CMD && b >= CH_LC_A && b <= CH_LC_Z) r.data = b - CASE_OFS;
    if ((r.kind == K_PARAM || r.kind == K_TRAIL) && ln_params != '0) begin
      r.pidx = ln_params - 1'b1;
      if (r.pidx > PIDX_SAT) r.pidx = PIDX_SAT;
    end
    if (last) begin
      // accepted only once a command was seen and nothing marked the line bad
      r.ok = (ln_phase >= PH_CMD) && (ln_phase <= PH_TRAIL) && !ln_bad;
      ln_phase = PH_LEAD;
      ln_count = '0;
      ln_params = '0;
      ln_bad = 1'b0;
    end
    return r;
  endfunction

  function automatic plan_row_t byte_row(input logic [7:0] b, input logic last);
    plan_row_t r;
    r = '0;
    r.op = ROW_BYTE;
    r.val = {1'b0, b};
    r.last = last;
    return r;
  endfunction

  // a byte whose label is written out by hand
  function automatic plan_row_t pinned_row(input logic [7:0] b, input logic last,
                                           input kind_t k, input logic [7:0] d,
                                           input logic st, input logic ok);
    plan_row_t r;
    r = byte_row(b, last);
    r.pinned = 1'b1;
    r.want.kind = k;
    r.want.data = d;
    r.want.start = st;
    r.want.line_end = last;
    r.want.ok = ok;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.op = ROW_REG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic logic [7:0] word_char();
    return 8'($urandom_range(33, 126));
  endfunction

  // command bytes: mostly letters of both cases, sometimes any printable
  function automatic logic [7:0] cmd_char();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return word_char();
    if (pick < 4) return 8'($urandom_range("A", "Z"));
    return 8'($urandom_range(CH_LC_A, CH_LC_Z));
  endfunction

  // trailing text: spaces, printable and high bytes, never nul or cr
  function automatic logic [7:0] trail_char();
    if ($urandom_range(0, 3) == 0) return CH_SPACE;
    return 8'($urandom_range(33, 255));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_in || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one byte, wait for the transaction, then record its expected label
  task automatic push_byte(input logic [7:0] b, input logic last, input logic pinned,
                           input tok_result_t want);
    int unsigned gap;
    tok_result_t label;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_line_byte <= b;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    label = label_byte(b, last);
    labels_due = {labels_due, (pinned ? want : label)};
    bytes_sent++;
  endtask

  // stop sending and let every outstanding label come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (labels_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // register writes only happen with the pipe empty
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_LINE) lim_bytes = val;
    else if (idx == CFG_MAX_PARAMS) lim_params = val[PCNT_W-1:0];
  endtask

  task automatic send_line();
    // some lines go out back to back with no sender gaps
    calm_in = ($urandom_range(0, 4) == 0);
    foreach (line_buf[i]) push_byte(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
    line_buf.delete();
  endtask

  // mostly well-formed lines with random content, the rest broken or noise
  task automatic build_line();
    int unsigned pick, k, nparm;
    logic [7:0] nb;
    pick = $urandom_range(0, 9);
    if (pick >= 8) begin
      // noise weighted toward the bytes the parser cares about
      repeat ($urandom_range(1, 12)) begin
        k = $urandom_range(0, 9);
        case (k)
          0: nb = CH_SPACE;
          1: nb = CH_COLON;
          2: nb = CH_CR;
          3: nb = CH_NUL;
          default: nb = 8'($urandom_range(0, 255));
        endcase
        add_byte(nb);
      end
    end else if (pick == 7) begin
      // prefix that never reaches a command
      add_byte(CH_COLON);
      repeat ($urandom_range(0, 5)) add_byte(word_char());
      repeat ($urandom_range(0, 2)) add_byte(CH_SPACE);
      if ($urandom_range(0, 1) == 1) add_byte(CH_CR);
    end else begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_byte(CH_SPACE);
      if ($urandom_range(0, 2) == 0) begin
        add_byte(CH_COLON);
        repeat ($urandom_range(0, 6)) add_byte(word_char());
        repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
      end
      repeat ($urandom_range(1, 6)) add_byte(cmd_char());
      // now and then enough words to saturate the parameter index
      nparm = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 36) : $urandom_range(0, 5);
      repeat (nparm) begin
        repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
        repeat ($urandom_range(1, 4)) add_byte(word_char());
      end
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
        add_byte(CH_COLON);
        repeat ($urandom_range(0, 10)) add_byte(trail_char());
      end
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
      if ($urandom_range(0, 3) != 0) add_byte(CH_CR);
    end
  endtask

  // result side: random stall pattern plus the compare against the oldest label
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (labels_due.size() == 0) begin
        $error("result with nothing outstanding: field_kind %0d out_byte %02h",
               out_field_kind, out_out_byte);
        mismatches++;
      end else begin
        due = labels_due.pop_front();
        if (out_field_kind !== due.kind) begin
          $error("field_kind: expected %0d, got %0d", due.kind, out_field_kind);
          mismatches++;
        end
        if (out_out_byte !== due.data) begin
          $error("out_byte: expected %02h, got %02h", due.data, out_out_byte);
          mismatches++;
        end
        if (out_param_index !== due.pidx) begin
          $error("param_index: expected %0d, got %0d", due.pidx, out_param_index);
          mismatches++;
        end
        if (out_field_start !== due.start) begin
          $error("field_start: expected %0d, got %0d", due.start, out_field_start);
          mismatches++;
        end
        if (out_line_end !== due.line_end) begin
          $error("line_end: expected %0d, got %0d", due.line_end, out_line_end);
          mismatches++;
        end
        if (out_line_ok !== due.ok) begin
          $error("line_ok: expected %0d, got %0d", due.ok, out_line_ok);
          mismatches++;
        end
      end
    end
    // each draw holds the stall level for a while: mostly short, a few long
    // stalls, and now and then a long stretch with no stall at all
    if (stall_hold != 0) stall_hold--;
    else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall <= 1'b0;
        stall_hold = $urandom_range(0, 4);
      end else if (stall_pick < 85) begin
        out_stall <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else if (stall_pick < 95) begin
        out_stall <= 1'b0;
        stall_hold = $urandom_range(20, 60);
      end else begin
        out_stall <= 1'b1;
        stall_hold = $urandom_range(15, 50);
      end
    end
  end

  // hang detector: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("irc_line_tokenizer_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned base, lng;
    logic [CFG_DAT_W-1:0] lb, lp;
    // every input known from time zero, reset asserted first
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_line_byte <= '0;
    in_is_last <= 1'b0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MAX_LINE;
    cfg_data <= '0;

    // prefix, command with lowercase and an embedded colon, empty trailing,
    // closing cr; the very first label is the one right after reset
    add_row(pinned_row(CH_COLON, 1'b0, K_SEP, CH_COLON, 1'b0, 1'b0));
    add_row(byte_row("p", 1'b0));
    add_row(byte_row(CH_SPACE, 1'b0));
    add_row(byte_row("a", 1'b0));
    add_row(byte_row(CH_COLON, 1'b0));
    add_row(byte_row("b", 1'b0));
    add_row(byte_row(CH_SPACE, 1'b0));
    add_row(byte_row(CH_COLON, 1'b0));
    add_row(byte_row(CH_CR, 1'b1));
    // line of nothing but spaces is rejected
    add_row(byte_row(CH_SPACE, 1'b0));
    add_row(pinned_row(CH_SPACE, 1'b1, K_SEP, CH_SPACE, 1'b0, 1'b0));
    // empty prefix is fine
    add_row(byte_row(CH_COLON, 1'b0));
    add_row(byte_row(CH_SPACE, 1'b0));
    add_row(byte_row("x", 1'b1));
    // prefix cut off by the end of line, top byte value
    add_row(byte_row(CH_COLON, 1'b0));
    add_row(pinned_row(8'hFF, 1'b1, K_PREFIX, 8'hFF, 1'b1, 1'b0));
    // prefix and space but no command
    add_row(byte_row(CH_COLON, 1'b0));
    add_row(byte_row(CH_SPACE, 1'b1));
    // nul alone: labelled as a command byte, line rejected
    add_row(pinned_row(CH_NUL, 1'b1, K_CMD, CH_NUL, 1'b1, 1'b0));
    // cr in the middle of a line
    add_row(byte_row("a", 1'b0));
    add_row(byte_row(CH_CR, 1'b0));
    add_row(byte_row("b", 1'b1));
    // writes to the unused indexes must leave both limits alone
    add_row(reg_row(CFG_SPARE_2, '0));
    add_row(reg_row(CFG_SPARE_3, '1));
    // no parameters allowed: one parameter is too many
    add_row(reg_row(CFG_MAX_PARAMS, '0));
    add_row(byte_row("x", 1'b0));
    add_row(byte_row(CH_SPACE, 1'b0));
    add_row(byte_row("y", 1'b1));
    // zero length limit rejects every line
    add_row(reg_row(CFG_MAX_LINE, '0));
    add_row(pinned_row("x", 1'b1, K_CMD, "X", 1'b1, 1'b0));
    // limit raised mid-line applies from the next byte
    add_row(reg_row(CFG_MAX_LINE, 9'd1));
    add_row(byte_row("a", 1'b0));
    add_row(reg_row(CFG_MAX_LINE, 9'd2));
    add_row(byte_row("b", 1'b1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].op == ROW_REG) write_limit(plan[i].idx, plan[i].val);
      else push_byte(plan[i].val[7:0], plan[i].last, plan[i].pinned, plan[i].want);
    end

    // random part, one limit setting per phase, extremes first
    base = bytes_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          lb = MAX_LINE_RST;
          lp = CFG_DAT_W'(MAX_PARAM_RST);
        end
        1: begin
          lb = 9'd1;
          lp = '0;
        end
        2: begin
          lb = LEN_SAT;
          lp = CFG_DAT_W'(PIDX_SAT);
        end
        3: begin
          lb = LEN_SAT;
          lp = CFG_DAT_W'(PCNT_SAT);
        end
        default: begin
          lb = ($urandom_range(0, 1) == 1) ? CFG_DAT_W'($urandom_range(4, 40))
                                           : CFG_DAT_W'($urandom_range(1, 511));
          // upper data bits are junk for the parameter limit
          lp = CFG_DAT_W'($urandom_range(0, 511));
        end
      endcase
      write_limit(CFG_MAX_LINE, lb);
      write_limit(CFG_MAX_PARAMS, lp);
      if (ph == 2) begin
        // one line around the top length, at times past the counter saturation
        lng = $urandom_range(509, 514);
        add_byte("P");
        add_byte(CH_SPACE);
        add_byte(CH_COLON);
        while (line_buf.size() < lng - 1) add_byte(trail_char());
        add_byte(CH_CR);
        send_line();
      end
      while (bytes_sent < base + (ph + 1) * PHASE_BYTES) begin
        build_line();
        send_line();
        // sender holds off until the pipe has drained
        if ($urandom_range(0, 19) == 0) settle();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && labels_due.size() == 0) begin
      $display("irc_line_tokenizer_core_tb OK");
    end else begin
      $display("irc_line_tokenizer_core_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/itok_pkg.sv
rtl/core/itok_step.sv
rtl/core/itok_out_stage.sv
rtl/core/irc_line_tokenizer_core.sv
sim/irc_line_tokenizer_core_tb.sv
